@@ rtl/bpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants, codes and helper functions of the barometric
// pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned RAW_W  = 24;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [WORD_W-1:0] C_B6_OFS     = 32'd4000;
	localparam logic [WORD_W-1:0] C_F2_COEF    = 32'd3038;
	localparam logic [WORD_W-1:0] C_F3_COEF    = 32'hFFFF_E343;
	localparam logic [WORD_W-1:0] C_F_OFS      = 32'd3791;
	localparam logic [WORD_W-1:0] C_B7_SCALE   = 32'd50000;
	localparam logic [WORD_W-1:0] C_SIGN_BIT   = 32'h8000_0000;
	localparam logic [WORD_W-1:0] C_B4_OFS     = 32'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OSS     = 3'd0,
		CFG_AC1_AC2 = 3'd1,
		CFG_AC3_AC4 = 3'd2,
		CFG_AC5_AC6 = 3'd3,
		CFG_B1_B2   = 3'd4,
		CFG_MC_MD   = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		KIND_TEMP  = 1'b0,
		KIND_PRESS = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_T_MUL,
		ST_T_DIV,
		ST_P_SQ,
		ST_P_X1A,
		ST_P_X2A,
		ST_P_X1B,
		ST_P_X2B,
		ST_P_B4,
		ST_P_B7,
		ST_P_DIV,
		ST_P_F1,
		ST_P_F2,
		ST_P_F3,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             opcode;
		logic [RAW_W-1:0] raw_value;
	} in_beat_t;

	typedef struct packed {
		logic                     measurement_kind;
		logic signed [WORD_W-1:0] result_value;
		logic signed [WORD_W-1:0] b5_value;
		logic                     status;
	} out_beat_t;

	function automatic logic [WORD_W-1:0] asr(input logic [WORD_W-1:0] v,
		input logic [4:0] n);
		return $unsigned($signed(v) >>> n);
	endfunction

	function automatic logic [WORD_W-1:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [WORD_W-1:0] zx16(input logic [15:0] v);
		return {16'd0, v};
	endfunction

endpackage

@@ rtl/bpc_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface bpc_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/bpc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_mul
// Bit-serial shift-and-add multiplier giving the low word of the product,
// one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module bpc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bpc_pkg::WORD_W-1:0]    a,
	input  logic [bpc_pkg::WORD_W-1:0]    b,
	output logic                          done,
	output logic [bpc_pkg::WORD_W-1:0]    product
);
	localparam int unsigned CNT_W = $clog2(bpc_pkg::WORD_W);

	logic [bpc_pkg::WORD_W-1:0] acc_q;
	logic [bpc_pkg::WORD_W-1:0] a_q;
	logic [bpc_pkg::WORD_W-1:0] b_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(bpc_pkg::WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[bpc_pkg::WORD_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[bpc_pkg::WORD_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

@@ rtl/bpc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_div
// Bit-serial restoring divider for unsigned words, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module bpc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bpc_pkg::WORD_W-1:0]    num,
	input  logic [bpc_pkg::WORD_W-1:0]    den,
	output logic                          done,
	output logic [bpc_pkg::WORD_W-1:0]    quotient
);
	localparam int unsigned CNT_W = $clog2(bpc_pkg::WORD_W);

	logic [bpc_pkg::WORD_W-1:0] quo_q;
	logic [bpc_pkg::WORD_W-1:0] rem_q;
	logic [bpc_pkg::WORD_W-1:0] den_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [bpc_pkg::WORD_W:0]   rem_sh;
	logic [bpc_pkg::WORD_W:0]   diff;

	assign rem_sh = {rem_q, quo_q[bpc_pkg::WORD_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(bpc_pkg::WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[bpc_pkg::WORD_W]) begin
				rem_q <= diff[bpc_pkg::WORD_W-1:0];
				quo_q <= {quo_q[bpc_pkg::WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[bpc_pkg::WORD_W-1:0];
				quo_q <= {quo_q[bpc_pkg::WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

@@ rtl/barometric_pressure_compensation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer compensation of raw temperature and pressure readings of a
// barometric sensor, using calibration words from the configuration port.
// ----------------------------------------------------------------------------
// One beat is worked on at a time. All products go through one bit-serial
// multiplier and the divisions through one bit-serial divider; each product or
// division holds the sequencer until its unit signals done. A temperature
// beat is worked as accept, one product, one division, result; a pressure
// beat as accept, seven products, one division, three more products, result.
// A zero divisor skips the division and what follows it. The result waits in
// an output register, so the next beat can be taken while the previous result
// has not yet been collected.
module barometric_pressure_compensation (
	input  logic                              clk,
	input  logic                              arst_n,
	bpc_stream_if.sink                        in_ch,
	bpc_stream_if.source                      out_ch,
	input  logic                              cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpc_pkg::WORD_W-1:0]        cfg_data
);
	localparam int unsigned W = bpc_pkg::WORD_W;

	logic [1:0]   oss_q;
	logic [W-1:0] ac1_ac2_q, ac3_ac4_q, ac5_ac6_q, b1_b2_q, mc_md_q;

	bpc_pkg::state_t    state_q, state_d;
	logic               issued_q;
	logic               mul_start, div_start, mul_done, div_done;
	logic [W-1:0]       mul_a, mul_b, mul_p, div_num, div_den, div_q;
	logic               in_ready;

	logic               kind_q;
	logic [15:0]        ut_q;
	logic [W-1:0]       up_q, b5_q, b6_q, x1_q, x2_q, sq_q, b3_q, b4_q, b7_q;
	logic [W-1:0]       pp_q, res_q;
	logic               status_q;
	logic               ovalid_q;
	bpc_pkg::out_beat_t out_q;

	logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [W-1:0] t_num, t_div, t_mag_num, t_mag_den;
	logic [W-1:0] x2_new, b3_sum, x3_sum, q_signed, f_sum;
	logic [W-1:0] up_new;
	logic         out_free;

	assign ac1 = bpc_pkg::sx16(ac1_ac2_q[31:16]);
	assign ac2 = bpc_pkg::sx16(ac1_ac2_q[15:0]);
	assign ac3 = bpc_pkg::sx16(ac3_ac4_q[31:16]);
	assign ac4 = bpc_pkg::zx16(ac3_ac4_q[15:0]);
	assign ac5 = bpc_pkg::zx16(ac5_ac6_q[31:16]);
	assign ac6 = bpc_pkg::zx16(ac5_ac6_q[15:0]);
	assign b1  = bpc_pkg::sx16(b1_b2_q[31:16]);
	assign b2  = bpc_pkg::sx16(b1_b2_q[15:0]);
	assign mc  = bpc_pkg::sx16(mc_md_q[31:16]);
	assign md  = bpc_pkg::sx16(mc_md_q[15:0]);

	assign t_num     = mc << 11;
	assign t_div     = x1_q + md;
	assign t_mag_num = t_num[W-1] ? (W'(0) - t_num) : t_num;
	assign t_mag_den = t_div[W-1] ? (W'(0) - t_div) : t_div;
	assign q_signed  = (t_num[W-1] != t_div[W-1]) ? (W'(0) - div_q) : div_q;

	assign x2_new = (state_q == bpc_pkg::ST_P_X2A) ? bpc_pkg::asr(mul_p, 5'd11)
		: bpc_pkg::asr(mul_p, 5'd16);
	assign b3_sum = (((ac1 << 2) + x1_q + x2_new) << oss_q) + W'(2);
	assign x3_sum = x1_q + x2_new + W'(2);
	assign f_sum  = x1_q + x2_new + bpc_pkg::C_F_OFS;
	assign up_new = {8'd0, in_ch.data.raw_value} >> (4'd8 - {2'd0, oss_q});

	assign out_free    = !ovalid_q || out_ch.ready;
	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q     <= '0;
			ac1_ac2_q <= '0;
			ac3_ac4_q <= '0;
			ac5_ac6_q <= '0;
			b1_b2_q   <= '0;
			mc_md_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bpc_pkg::CFG_OSS:     oss_q     <= cfg_data[1:0];
				bpc_pkg::CFG_AC1_AC2: ac1_ac2_q <= cfg_data;
				bpc_pkg::CFG_AC3_AC4: ac3_ac4_q <= cfg_data;
				bpc_pkg::CFG_AC5_AC6: ac5_ac6_q <= cfg_data;
				bpc_pkg::CFG_B1_B2:   b1_b2_q   <= cfg_data;
				bpc_pkg::CFG_MC_MD:   mc_md_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		in_ready  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			bpc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_ch.valid) begin
					state_d = (in_ch.data.opcode == bpc_pkg::KIND_PRESS)
						? bpc_pkg::ST_P_SQ : bpc_pkg::ST_T_MUL;
				end
			end
			bpc_pkg::ST_T_DIV: begin
				div_num = t_mag_num;
				div_den = t_mag_den;
				if (!issued_q) begin
					if (t_div == '0) begin
						state_d = bpc_pkg::ST_DONE;
					end else begin
						div_start = 1'b1;
					end
				end else if (div_done) begin
					state_d = bpc_pkg::ST_DONE;
				end
			end
			bpc_pkg::ST_P_DIV: begin
				div_num = b7_q[W-1] ? b7_q : (b7_q << 1);
				div_den = b4_q;
				if (!issued_q) begin
					if (b4_q == '0) begin
						state_d = bpc_pkg::ST_DONE;
					end else begin
						div_start = 1'b1;
					end
				end else if (div_done) begin
					state_d = bpc_pkg::ST_P_F1;
				end
			end
			bpc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = bpc_pkg::ST_IDLE;
				end
			end
			default: begin
				case (state_q)
					bpc_pkg::ST_T_MUL: begin
						mul_a = bpc_pkg::zx16(ut_q) - ac6;
						mul_b = ac5;
					end
					bpc_pkg::ST_P_SQ: begin
						mul_a = b6_q;
						mul_b = b6_q;
					end
					bpc_pkg::ST_P_X1A: begin
						mul_a = sq_q;
						mul_b = b2;
					end
					bpc_pkg::ST_P_X2A: begin
						mul_a = ac2;
						mul_b = b6_q;
					end
					bpc_pkg::ST_P_X1B: begin
						mul_a = ac3;
						mul_b = b6_q;
					end
					bpc_pkg::ST_P_X2B: begin
						mul_a = b1;
						mul_b = sq_q;
					end
					bpc_pkg::ST_P_B4: begin
						mul_a = ac4;
						mul_b = x2_q + bpc_pkg::C_B4_OFS;
					end
					bpc_pkg::ST_P_B7: begin
						mul_a = up_q - b3_q;
						mul_b = bpc_pkg::C_B7_SCALE >> oss_q;
					end
					bpc_pkg::ST_P_F1: begin
						mul_a = pp_q;
						mul_b = pp_q;
					end
					bpc_pkg::ST_P_F2: begin
						mul_a = x1_q;
						mul_b = bpc_pkg::C_F2_COEF;
					end
					default: begin
						mul_a = bpc_pkg::C_F3_COEF;
						mul_b = pp_q;
					end
				endcase
				if (!issued_q) begin
					mul_start = 1'b1;
				end else if (mul_done) begin
					case (state_q)
						bpc_pkg::ST_T_MUL: state_d = bpc_pkg::ST_T_DIV;
						bpc_pkg::ST_P_SQ:  state_d = bpc_pkg::ST_P_X1A;
						bpc_pkg::ST_P_X1A: state_d = bpc_pkg::ST_P_X2A;
						bpc_pkg::ST_P_X2A: state_d = bpc_pkg::ST_P_X1B;
						bpc_pkg::ST_P_X1B: state_d = bpc_pkg::ST_P_X2B;
						bpc_pkg::ST_P_X2B: state_d = bpc_pkg::ST_P_B4;
						bpc_pkg::ST_P_B4:  state_d = bpc_pkg::ST_P_B7;
						bpc_pkg::ST_P_B7:  state_d = bpc_pkg::ST_P_DIV;
						bpc_pkg::ST_P_F1:  state_d = bpc_pkg::ST_P_F2;
						bpc_pkg::ST_P_F2:  state_d = bpc_pkg::ST_P_F3;
						default:           state_d = bpc_pkg::ST_DONE;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bpc_pkg::ST_IDLE;
			issued_q <= 1'b0;
			ovalid_q <= 1'b0;
			b5_q     <= '0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end else if (mul_done || div_done) begin
				issued_q <= 1'b0;
			end
			if (state_q == bpc_pkg::ST_T_DIV && issued_q && div_done) begin
				b5_q <= x1_q + q_signed;
			end
			if (state_q == bpc_pkg::ST_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bpc_pkg::ST_IDLE && in_ch.valid) begin
			kind_q   <= in_ch.data.opcode;
			ut_q     <= in_ch.data.raw_value[15:0];
			up_q     <= up_new;
			b6_q     <= b5_q - bpc_pkg::C_B6_OFS;
			res_q    <= '0;
			status_q <= 1'b0;
		end
		if (state_q == bpc_pkg::ST_T_DIV && !issued_q && t_div == '0) begin
			status_q <= 1'b1;
		end
		if (state_q == bpc_pkg::ST_P_DIV && !issued_q && b4_q == '0) begin
			status_q <= 1'b1;
		end
		if (state_q == bpc_pkg::ST_T_DIV && issued_q && div_done) begin
			res_q <= bpc_pkg::asr(x1_q + q_signed + W'(8), 5'd4);
		end
		if (state_q == bpc_pkg::ST_P_DIV && issued_q && div_done) begin
			pp_q <= b7_q[W-1] ? (div_q << 1) : div_q;
		end
		if (issued_q && mul_done) begin
			case (state_q)
				bpc_pkg::ST_T_MUL: x1_q <= bpc_pkg::asr(mul_p, 5'd15);
				bpc_pkg::ST_P_SQ:  sq_q <= bpc_pkg::asr(mul_p, 5'd12);
				bpc_pkg::ST_P_X1A: x1_q <= bpc_pkg::asr(mul_p, 5'd11);
				bpc_pkg::ST_P_X2A: b3_q <= bpc_pkg::asr(b3_sum, 5'd2);
				bpc_pkg::ST_P_X1B: x1_q <= bpc_pkg::asr(mul_p, 5'd13);
				bpc_pkg::ST_P_X2B: x2_q <= bpc_pkg::asr(x3_sum, 5'd2);
				bpc_pkg::ST_P_B4:  b4_q <= mul_p >> 15;
				bpc_pkg::ST_P_B7:  b7_q <= mul_p;
				bpc_pkg::ST_P_F1:  x1_q <= bpc_pkg::asr(mul_p, 5'd16);
				bpc_pkg::ST_P_F2:  x1_q <= bpc_pkg::asr(mul_p, 5'd16);
				bpc_pkg::ST_P_F3:  res_q <= pp_q + bpc_pkg::asr(f_sum, 5'd4);
				default: ;
			endcase
		end
		if (state_q == bpc_pkg::ST_DONE && out_free) begin
			out_q.measurement_kind <= kind_q;
			out_q.result_value     <= $signed(res_q);
			out_q.b5_value         <= $signed(b5_q);
			out_q.status           <= status_q;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = out_q;

	bpc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	bpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_num),
		.den      (div_den),
		.done     (div_done),
		.quotient (div_q)
	);
endmodule
